/* sv/tkmh_pkg.sv */
`timescale 1ns / 1ps

package tkmh_pkg;

   // Heap geometry.
   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CH_W     = ADDR_W + 2;

   // Field widths fixed by the interface.
   localparam int VAL_W  = 31;
   localparam int K_W    = 11;
   localparam int KEPT_W = 11;

   // Reset value of the k_keep register.
   localparam logic [K_W-1:0] K_KEEP_RESET = K_W'(1024);

   // Item commands.
   localparam logic CMD_OFFER = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP,
      ST_LAST_WAIT,
      ST_RESP
   } state_type;

   // Datapath operations, one per cycle.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_INS_BEGIN,
      OP_REP_BEGIN,
      OP_POP_BEGIN,
      OP_POP_LOAD,
      OP_UP_READ,
      OP_UP_MOVE,
      OP_DN_READ,
      OP_DN_MOVE,
      OP_PLACE,
      OP_RESP
   } op_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_drain;
      logic count_zero;
      logic ins_ok;
      logic rep_ok;
      logic pos_zero;
      logic up_less;
      logic has_left;
      logic dn_go;
   } status_type;

endpackage

/* sv/tkmh_ram.sv */
`timescale 1ns / 1ps

module tkmh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // One write port and two registered read ports.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* sv/tkmh_ctrl.sv */
`timescale 1ns / 1ps

module tkmh_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  tkmh_pkg::status_type status,
   output tkmh_pkg::op_type    op,
   output logic                busy
);

   import tkmh_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and the datapath operation for this cycle.
   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op       = OP_LOAD;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.is_drain) begin
               if (status.count_zero) begin
                  state_in = ST_RESP;
               end else begin
                  op       = OP_POP_BEGIN;
                  state_in = ST_LAST_WAIT;
               end
            end else if (status.ins_ok) begin
               op       = OP_INS_BEGIN;
               state_in = ST_UP_RD;
            end else if (status.rep_ok) begin
               op       = OP_REP_BEGIN;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_LAST_WAIT: begin
            if (status.count_zero) begin
               state_in = ST_RESP;
            end else begin
               op       = OP_POP_LOAD;
               state_in = ST_DN_RD;
            end
         end
         ST_UP_RD: begin
            if (status.pos_zero) begin
               op       = OP_PLACE;
               state_in = ST_RESP;
            end else begin
               op       = OP_UP_READ;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (status.up_less) begin
               op       = OP_UP_MOVE;
               state_in = ST_UP_RD;
            end else begin
               op       = OP_PLACE;
               state_in = ST_RESP;
            end
         end
         ST_DN_RD: begin
            if (status.has_left) begin
               op       = OP_DN_READ;
               state_in = ST_DN_CMP;
            end else begin
               op       = OP_PLACE;
               state_in = ST_RESP;
            end
         end
         ST_DN_CMP: begin
            if (status.dn_go) begin
               op       = OP_DN_MOVE;
               state_in = ST_DN_RD;
            end else begin
               op       = OP_PLACE;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            op       = OP_RESP;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

/* sv/tkmh_dp.sv */
`timescale 1ns / 1ps

module tkmh_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  tkmh_pkg::op_type              op,
   output tkmh_pkg::status_type          status,
   input  logic                          req_command,
   input  logic [tkmh_pkg::VAL_W-1:0]    req_value,
   input  logic                          csr_wr_en,
   input  logic [tkmh_pkg::K_W-1:0]      csr_k_keep,
   output logic                          rsp_strobe,
   output logic [tkmh_pkg::VAL_W-1:0]    rsp_result_value,
   output logic                          rsp_valid_res,
   output logic [tkmh_pkg::KEPT_W-1:0]   rsp_kept_count
);

   import tkmh_pkg::*;

   logic [K_W-1:0]    k_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic              cmd_ff;
   logic [VAL_W-1:0]  val_ff;
   logic [VAL_W-1:0]  root_ff;
   logic [VAL_W-1:0]  mov_ff;
   logic [VAL_W-1:0]  mov_in;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic [VAL_W-1:0]  pop_ff;
   logic              pop_valid_ff;

   logic [CNT_W-1:0]  keff;
   logic [ADDR_W-1:0] parent;
   logic [CH_W-1:0]   left;
   logic [CH_W-1:0]   right;
   logic              has_right;
   logic              pick_right;
   logic [VAL_W-1:0]  pick_val;
   logic [ADDR_W-1:0] pick_pos;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [VAL_W-1:0]  wr_data;
   logic [ADDR_W-1:0] rd_addr_a;
   logic [VAL_W-1:0]  rd_data_a;
   logic [VAL_W-1:0]  rd_data_b;

   // Effective keep count: zero acts as one, anything above the capacity as the capacity.
   always_comb begin
      if (32'(k_ff) > CAPACITY) begin
         keff = CNT_W'(CAPACITY);
      end else if (k_ff == '0) begin
         keff = CNT_W'(1);
      end else begin
         keff = CNT_W'(k_ff);
      end
   end

   // Heap index arithmetic around the current hole position.
   assign parent    = ADDR_W'((pos_ff - ADDR_W'(1)) >> 1);
   assign left      = CH_W'({pos_ff, 1'b1});
   assign right     = left + CH_W'(1);
   assign has_right = (right < CH_W'(count_ff));

   // Child selection for the sift-down; the right child wins ties.
   assign pick_right = has_right && (rd_data_b <= rd_data_a);
   assign pick_val   = pick_right ? rd_data_b : rd_data_a;
   assign pick_pos   = pick_right ? ADDR_W'(right) : ADDR_W'(left);

   // Status toward the controller.
   always_comb begin
      status.is_drain   = (cmd_ff == CMD_DRAIN);
      status.count_zero = (count_ff == '0);
      status.ins_ok     = (count_ff < keff);
      status.rep_ok     = (count_ff != '0) && (val_ff >= root_ff);
      status.pos_zero   = (pos_ff == '0);
      status.up_less    = (mov_ff < rd_data_a);
      status.has_left   = (left < CH_W'(count_ff));
      status.dn_go      = (mov_ff > pick_val);
   end

   // Memory port control.
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = pos_ff;
      wr_data   = mov_ff;
      rd_addr_a = ADDR_W'(left);
      case (op)
         OP_PLACE: begin
            wr_en = 1'b1;
         end
         OP_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_data_a;
         end
         OP_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = pick_val;
         end
         OP_UP_READ: begin
            rd_addr_a = parent;
         end
         OP_POP_BEGIN: begin
            rd_addr_a = ADDR_W'(count_ff - CNT_W'(1));
         end
         default: begin
         end
      endcase
   end

   // Next values of the moving value, hole position and count.
   always_comb begin
      mov_in   = mov_ff;
      pos_in   = pos_ff;
      count_in = count_ff;
      case (op)
         OP_INS_BEGIN: begin
            mov_in   = val_ff;
            pos_in   = ADDR_W'(count_ff);
            count_in = count_ff + CNT_W'(1);
         end
         OP_REP_BEGIN: begin
            mov_in = val_ff;
            pos_in = '0;
         end
         OP_POP_BEGIN: begin
            count_in = count_ff - CNT_W'(1);
         end
         OP_POP_LOAD: begin
            mov_in = rd_data_a;
            pos_in = '0;
         end
         OP_UP_MOVE: begin
            pos_in = parent;
         end
         OP_DN_MOVE: begin
            pos_in = pick_pos;
         end
         default: begin
         end
      endcase
   end

   // Control registers: count and the keep register.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         k_ff     <= K_KEEP_RESET;
      end else begin
         count_ff <= count_in;
         if (csr_wr_en) begin
            k_ff <= csr_k_keep;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mov_ff <= mov_in;
      pos_ff <= pos_in;
      if (op == OP_LOAD) begin
         cmd_ff       <= req_command;
         val_ff       <= req_value;
         pop_ff       <= '0;
         pop_valid_ff <= 1'b0;
      end else if (op == OP_POP_BEGIN) begin
         pop_ff       <= root_ff;
         pop_valid_ff <= 1'b1;
      end
      // Shadow copy of the root entry.
      if (wr_en && (wr_addr == '0)) begin
         root_ff <= wr_data;
      end
   end

   tkmh_ram #(
      .WIDTH (VAL_W),
      .DEPTH (CAPACITY)
   ) u_heap_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (rd_addr_a),
      .rd_addr_b (ADDR_W'(right)),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // Result item.
   assign rsp_strobe       = (op == OP_RESP);
   assign rsp_result_value = (cmd_ff == CMD_DRAIN) ? pop_ff : root_ff;
   assign rsp_valid_res    = (cmd_ff == CMD_DRAIN) ? pop_valid_ff : (count_ff != '0);
   assign rsp_kept_count   = KEPT_W'(count_ff);

endmodule

/* sv/top_k_min_heap_selector_top.sv */
// A dropped offer or an empty drain passes only the accept, decide and response states; an insert,
// replace or drain also walks the heap, level by level, before the result strobe.
// Each heap level takes one registered memory read, then a compare and write.
// One item at a time; busy falls in the cycle after the strobe, where the next item can be
// accepted.
// Reset clears the count and sets k_keep to 1024 but not the heap; the receiver cannot stall.
`timescale 1ns / 1ps

module top_k_min_heap_selector_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_command,
   input  logic [tkmh_pkg::VAL_W-1:0]    req_value,
   input  logic                          csr_wr_en,
   input  logic [tkmh_pkg::K_W-1:0]      csr_k_keep,
   output logic                          rsp_strobe,
   output logic [tkmh_pkg::VAL_W-1:0]    rsp_result_value,
   output logic                          rsp_valid_res,
   output logic [tkmh_pkg::KEPT_W-1:0]   rsp_kept_count
);

   import tkmh_pkg::*;

   op_type     op;
   status_type status;

   // Sequencer for insert, replace and pop.
   tkmh_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   // Heap memory, count and compare logic.
   tkmh_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .status           (status),
      .req_command      (req_command),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_k_keep       (csr_k_keep),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_kept_count   (rsp_kept_count)
   );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import tkmh_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

   // One expected result as the block reports it.
   typedef struct {
      logic [VAL_W-1:0]  value;
      logic              valid;
      logic [KEPT_W-1:0] count;
   } heap_result_type;

   // Tracks the kept values in its own min-heap and checks each reported result.
   class topk_tracker;
      logic [VAL_W-1:0] slots [0:CAPACITY-1];
      int unsigned      kept;
      logic [K_W-1:0]   k_reg;
      heap_result_type  due_results [$];
      int unsigned      mismatches;
      int unsigned      checked;

      function void clear();
         kept = 0;
         k_reg = K_KEEP_RESET;
         mismatches = 0;
         checked = 0;
         due_results.delete();
      endfunction

      function void write_k(logic [K_W-1:0] k);
         k_reg = k;
      endfunction

      // A zero register acts as one, anything above the capacity as the capacity.
      function int unsigned keep_limit();
         if (k_reg == 0) return 1;
         if (k_reg > CAPACITY) return CAPACITY;
         return k_reg;
      endfunction

      function logic [VAL_W-1:0] smallest();
         return (kept > 0) ? slots[0] : '0;
      endfunction

      function int outstanding();
         return due_results.size();
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         logic [VAL_W-1:0] t;
         t = slots[a];
         slots[a] = slots[b];
         slots[b] = t;
      endfunction

      function void raise_entry(int unsigned pos);
         int unsigned parent;
         while (pos > 0) begin
            parent = (pos - 1) / 2;
            if (slots[pos] < slots[parent]) begin
               swap_slots(pos, parent);
               pos = parent;
            end else begin
               break;
            end
         end
      endfunction

      // On equal children the right one is taken.
      function void lower_entry(int unsigned pos);
         int unsigned left;
         int unsigned pick;
         forever begin
            left = 2 * pos + 1;
            if (left >= kept) return;
            pick = left;
            if (left + 1 < kept && slots[left + 1] <= slots[left]) pick = left + 1;
            if (slots[pos] > slots[pick]) begin
               swap_slots(pos, pick);
               pos = pick;
            end else begin
               return;
            end
         end
      endfunction

      // Applies one accepted item and queues the result it must produce.
      function void note_item(logic cmd, logic [VAL_W-1:0] v);
         heap_result_type r;
         r.value = '0;
         r.valid = 1'b0;
         if (cmd == CMD_OFFER) begin
            if (kept < keep_limit()) begin
               slots[kept] = v;
               kept++;
               raise_entry(kept - 1);
            end else if (kept > 0 && v >= slots[0]) begin
               slots[0] = v;
               lower_entry(0);
            end
            if (kept > 0) begin
               r.value = slots[0];
               r.valid = 1'b1;
            end
         end else if (kept > 0) begin
            r.value = slots[0];
            r.valid = 1'b1;
            kept--;
            slots[0] = slots[kept];
            lower_entry(0);
         end
         r.count = KEPT_W'(kept);
         due_results.push_back(r);
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(logic [VAL_W-1:0] v, logic ok, logic [KEPT_W-1:0] n);
         heap_result_type want;
         checked++;
         if (due_results.size() == 0) begin
            flag($sformatf("result %0d unexpected: value %h valid %b count %0d",
                           checked, v, ok, n));
            return;
         end
         want = due_results.pop_front();
         if (v !== want.value || ok !== want.valid || n !== want.count)
            flag($sformatf({"result %0d: expected value %h valid %b count %0d,",
                            " got value %h valid %b count %0d"},
                           checked, want.value, want.valid, want.count, v, ok, n));
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_command;
   logic [VAL_W-1:0]  req_value;
   logic              csr_wr_en;
   logic [K_W-1:0]    csr_k_keep;
   logic              rsp_strobe;
   logic [VAL_W-1:0]  rsp_result_value;
   logic              rsp_valid_res;
   logic [KEPT_W-1:0] rsp_kept_count;

   topk_tracker sb;
   int          burst_left;
   int          cycle_count;

   top_k_min_heap_selector_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_value        (req_value),
      .csr_wr_en        (csr_wr_en),
      .csr_k_keep       (csr_k_keep),
      .rsp_strobe       (rsp_strobe),
      .rsp_result_value (rsp_result_value),
      .rsp_valid_res    (rsp_valid_res),
      .rsp_kept_count   (rsp_kept_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Results are checked before a new item is noted at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) sb.check_result(rsp_result_value, rsp_valid_res, rsp_kept_count);
         if (start && !busy) sb.note_item(req_command, req_value);
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Sends one item; between bursts of random length the sender idles for a random gap, or not at all.
   task automatic send_item(input logic cmd, input logic [VAL_W-1:0] v);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_command <= cmd;
      req_value <= v;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // Writes k_keep once every result is in and the block is idle.
   task automatic load_k(input logic [K_W-1:0] k);
      start <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      csr_k_keep <= k;
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      sb.write_k(k);
   endtask

   // Values cluster at the ends of the range and around the current smallest kept value; the rest are uniform.
   function automatic logic [VAL_W-1:0] pick_value();
      logic [VAL_W-1:0] base;
      base = sb.smallest();
      case ($urandom_range(0, 4))
         0: return VAL_W'($urandom_range(0, 15));
         1: return VAL_MAX - VAL_W'($urandom_range(0, 15));
         2: return VAL_W'(base + $urandom_range(0, 2) - 1);
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic run_phase(input logic [K_W-1:0] k, input int items, input int drain_pct);
      logic cmd;
      load_k(k);
      for (int i = 0; i < items; i++) begin
         cmd = ($urandom_range(0, 99) < drain_pct) ? CMD_DRAIN : CMD_OFFER;
         send_item(cmd, pick_value());
      end
   endtask

   initial begin
      sb = new();
      sb.clear();
      burst_left = 0;
      cycle_count = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_OFFER;
      req_value = '0;
      csr_wr_en = 1'b0;
      csr_k_keep = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty drain, extreme values and duplicates at the reset k_keep.
      send_item(CMD_DRAIN, VAL_MAX);
      send_item(CMD_OFFER, '0);
      send_item(CMD_OFFER, VAL_MAX);
      send_item(CMD_OFFER, VAL_MAX);
      send_item(CMD_OFFER, 31'h2AAAAAAA);
      send_item(CMD_OFFER, 31'h55555555);
      send_item(CMD_OFFER, 31'd1);
      send_item(CMD_DRAIN, '0);
      send_item(CMD_DRAIN, '0);

      // Lowering k_keep below the count: a drop, equal replace, larger replace, drain to empty.
      load_k(11'd1);
      send_item(CMD_OFFER, 31'd5);
      send_item(CMD_OFFER, 31'h2AAAAAAA);
      send_item(CMD_OFFER, 31'h60000000);
      repeat (5) send_item(CMD_DRAIN, '0);

      // A zero k_keep keeps one value.
      load_k(11'd0);
      send_item(CMD_OFFER, 31'd7);
      send_item(CMD_OFFER, 31'd6);
      send_item(CMD_OFFER, 31'd7);
      send_item(CMD_DRAIN, '0);

      // All ones in k_keep acts as the capacity.
      load_k(11'h7FF);
      send_item(CMD_OFFER, 31'd3);
      send_item(CMD_OFFER, 31'd2);
      repeat (3) send_item(CMD_DRAIN, VAL_MAX);

      // Random phases; the long one fills the heap to capacity, the next one trims it.
      run_phase(11'd3, 50, 30);
      run_phase(11'h7FF, 60, 20);
      run_phase(11'd1, 40, 40);
      run_phase(11'd0, 30, 40);
      run_phase(11'd17, 60, 35);
      run_phase(11'd1025, 50, 60);
      run_phase(11'd64, 60, 25);
      run_phase(11'd1024, 1070, 1);
      run_phase(11'd17, 60, 45);
      run_phase(11'd500, 60, 30);

      start <= 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
